@@ hw/rtl/mtep_pkg.sv @@
// Shared types and constants of the MIDI track event parser.
package mtep_pkg;

  localparam int TIME_W = 40;
  localparam int MPQN_W = 24;
  localparam int DIV_W = 15;
  localparam int OFS_W = 21;
  localparam int M_DATA_W = 128;
  localparam int CODE_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
  localparam logic [MPQN_W-1:0] DEFAULT_MPQN = 24'd500000;
  localparam logic [7:0] META_END = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] STATUS_META = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
  localparam logic [14:0] DEFAULT_DIVISION = 15'd480;

  localparam logic CFG_TIME_DIV = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    RC_EVENT     = 3'd0,
    RC_END       = 3'd1,
    RC_BAD_RUN   = 3'd2,
    RC_BAD_EVENT = 3'd3,
    RC_NEG_TIME  = 3'd4,
    RC_TRUNC     = 3'd5
  } result_code_t;

endpackage

@@ hw/rtl/mtep_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/mtep_seg.sv @@
// Tempo segment unit: floor(ticks * mpqn / division), saturated, by shift-add and restoring divide.
module mtep_seg #(
  parameter int TW = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [TW-1:0]              ticks,
  input  logic [mtep_pkg::MPQN_W-1:0] mpqn,
  input  logic [mtep_pkg::DIV_W-1:0]  div,
  output logic                       done,
  output logic [mtep_pkg::TIME_W-1:0] result
);
  import mtep_pkg::*;

  localparam int PW = TW + MPQN_W;
  localparam int NW = $clog2(PW + 1);

  typedef enum logic [2:0] {
    SG_IDLE = 3'b001,
    SG_MUL  = 3'b010,
    SG_DIV  = 3'b100
  } sg_state_t;

  sg_state_t         st;
  logic [NW-1:0]     cnt;
  logic [PW-1:0]     acc;
  logic [MPQN_W-1:0] mq;
  logic [TW-1:0]     tv;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dv;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  assign trial = {rem, acc[PW-1]};
  assign ge = trial >= {1'b0, dv};
  assign diff = trial - {1'b0, dv};
  assign result = (acc > PW'(TIME_MAX)) ? TIME_MAX : acc[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SG_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        SG_IDLE: begin
          if (start) begin
            tv <= ticks;
            mq <= mpqn;
            acc <= '0;
            dv <= div;
            cnt <= NW'(MPQN_W);
            st <= SG_MUL;
          end
        end
        SG_MUL: begin
          // multiplier bits MSB first
          acc <= {acc[PW-2:0], 1'b0} + (mq[MPQN_W-1] ? PW'(tv) : '0);
          mq <= {mq[MPQN_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == NW'(1)) begin
            cnt <= NW'(PW);
            rem <= '0;
            st <= SG_DIV;
          end
        end
        SG_DIV: begin
          // quotient bits shift into acc as dividend bits shift out
          rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
          acc <= {acc[PW-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == NW'(1)) begin
            st <= SG_IDLE;
            done <= 1'b1;
          end
        end
        default: st <= SG_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/midi_track_event_parser.sv @@
// Standard MIDI File track event parser: byte-serial decoder with tempo map and timestamps.
// One track byte is taken per request. Bytes that only advance the parser keep the sequencer idle;
// a byte that yields a result without a timestamp passes through the emit state, and the next
// byte waits until that result is taken.
// A tempo change (tempo pass) and every timed event (event pass) run the shared segment
// unit: 24 multiply steps plus TICK_WIDTH+24 divide steps, plus the control states, and the
// event pass first walks the tempo table from the saved cursor, through ST_LK_CHK and ST_LK_NXT
// for each entry passed, using the table RAM's read port.
// A new byte is accepted only when the unit is idle and the result register is empty.
module midi_track_event_parser #(
  parameter int TEMPO_ENTRIES = 64,
  parameter int TICK_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  input  logic [1:0]                    s_tuser,   // pass_select, track_start
  input  logic                          s_tlast,   // track_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // event_tick[31:0], status_byte[39:32], meta_kind[47:40], event_bytes[79:48],
  // used_running[80], time_us[120:81], tempo_overflow[121], zero pad
  output logic [mtep_pkg::M_DATA_W-1:0] m_tdata,
  output logic [mtep_pkg::CODE_W-1:0]   m_tuser,   // result_code
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [mtep_pkg::OFS_W-1:0]    cfg_data
);
  import mtep_pkg::*;

  localparam int AW = (TEMPO_ENTRIES > 1) ? $clog2(TEMPO_ENTRIES) : 1;
  localparam int CW = $clog2(TEMPO_ENTRIES + 1);
  localparam int SW = ((TICK_WIDTH > 32) ? TICK_WIDTH : 32) + 1;
  localparam int EW = TICK_WIDTH + MPQN_W + TIME_W;
  localparam logic [SW-1:0] TICK_MAX = SW'({TICK_WIDTH{1'b1}});

  typedef enum logic [5:0] {
    PH_DELTA  = 6'b000001,
    PH_STATUS = 6'b000010,
    PH_META   = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_TSTART = 10'b0000000010,
    ST_LK_CHK = 10'b0000000100,
    ST_LK_NXT = 10'b0000001000,
    ST_LK_CUR = 10'b0000010000,
    ST_SEG    = 10'b0000100000,
    ST_TWR    = 10'b0001000000,
    ST_TSUM   = 10'b0010000000,
    ST_TOFS   = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } seq_state_t;

  // configuration
  logic [DIV_W-1:0]        time_division;
  logic signed [OFS_W-1:0] offset_ms;
  logic signed [30:0]      off_us;

  // parser state
  phase_t                  phase, phase_next;
  logic [TICK_WIDTH-1:0]   tick_count, tick_count_next;
  logic [7:0]              last_status, last_status_next;
  logic [31:0]             vlq, vlq_next;
  logic [31:0]             skip, skip_next;
  logic [7:0]              cur_status, cur_status_next;
  logic [7:0]              cur_meta, cur_meta_next;
  logic [31:0]             cur_size, cur_size_next;
  logic [MPQN_W-1:0]       tempo_bytes, tempo_bytes_next;
  logic [TICK_WIDTH-1:0]   tst, tst_next;
  logic                    running, running_next;
  logic [TIME_W-1:0]       run_time, run_time_next;
  logic [MPQN_W-1:0]       mpqn, mpqn_next;
  logic [CW-1:0]           tempo_count, tempo_count_next;
  logic [AW-1:0]           cursor, cursor_next;
  logic                    overflow, overflow_next;

  // sequencer
  seq_state_t              st, st_next;
  logic                    job_tempo, job_tempo_next;
  logic                    job_last, job_last_next;
  result_code_t            res_code, res_code_next;
  logic                    res_stored, res_stored_next;
  logic [TIME_W-1:0]       res_time, res_time_next;
  logic [TIME_W-1:0]       base_us, base_us_next;
  logic [TIME_W-1:0]       lk_us, lk_us_next;
  logic                    out_load;

  // table RAM and segment unit
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;
  logic [TICK_WIDTH-1:0]   rd_tick;
  logic [MPQN_W-1:0]       rd_mpqn;
  logic [TIME_W-1:0]       rd_time;
  logic                    seg_start, seg_done;
  logic [TICK_WIDTH-1:0]   seg_ticks;
  logic [MPQN_W-1:0]       seg_mpqn;
  logic [DIV_W-1:0]        seg_div;
  logic [TIME_W-1:0]       seg_res;

  logic                    s_accept;
  logic [31:0]             stored_bytes;
  logic [31:0]             tick32;
  logic [47:0]             tick48;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = (st == ST_IDLE) && !m_tvalid;
  assign cfg_ready = 1'b1;
  assign seg_div = (time_division == '0) ? DIV_W'(1) : time_division;
  assign {rd_tick, rd_mpqn, rd_time} = ram_rdata;

  assign stored_bytes = running ? cur_size :
                        ((cur_size == U32_MAX) ? U32_MAX : cur_size + 32'd1);
  assign tick48 = 48'(tick_count);
  assign tick32 = (tick48 > 48'(U32_MAX)) ? U32_MAX : tick48[31:0];

  always_comb begin
    logic [7:0]        b;
    logic              pass;
    logic              last;
    logic              cmpl;
    logic              early;
    logic              n_res;
    logic [3:0]        hi;
    logic [SW-1:0]     tsum;
    logic [SW-1:0]     ssum;
    logic [31:0]       size1;
    logic [33:0]       lsum;
    logic [31:0]       idx;
    logic [AW-1:0]     cur;
    logic [TIME_W:0]   tsat;
    logic signed [41:0] total;

    b = s_tdata;
    pass = s_tuser[0];
    last = s_tlast;
    cmpl = 1'b0;
    early = 1'b0;
    n_res = 1'b0;
    hi = '0;
    tsum = '0;
    ssum = '0;
    size1 = '0;
    lsum = '0;
    idx = '0;
    cur = '0;
    tsat = '0;
    total = '0;

    phase_next = phase;
    tick_count_next = tick_count;
    last_status_next = last_status;
    vlq_next = vlq;
    skip_next = skip;
    cur_status_next = cur_status;
    cur_meta_next = cur_meta;
    cur_size_next = cur_size;
    tempo_bytes_next = tempo_bytes;
    tst_next = tst;
    running_next = running;
    run_time_next = run_time;
    mpqn_next = mpqn;
    tempo_count_next = tempo_count;
    cursor_next = cursor;
    overflow_next = overflow;
    st_next = st;
    job_tempo_next = job_tempo;
    job_last_next = job_last;
    res_code_next = res_code;
    res_stored_next = res_stored;
    res_time_next = res_time;
    base_us_next = base_us;
    lk_us_next = lk_us;
    out_load = 1'b0;
    ram_we = 1'b0;
    ram_waddr = tempo_count[AW-1:0];
    ram_wdata = {tick_count, tempo_bytes, run_time};
    ram_raddr = cursor;
    seg_start = 1'b0;
    seg_ticks = tick_count;
    seg_mpqn = DEFAULT_MPQN;

    unique case (st)
      ST_IDLE: begin
        if (s_accept) begin
          st_next = ST_IDLE;
          if (s_tuser[1]) begin
            phase_next = PH_DELTA;
            tick_count_next = '0;
            last_status_next = '0;
            vlq_next = '0;
            skip_next = '0;
            cur_status_next = '0;
            cur_meta_next = '0;
            cur_size_next = '0;
            tempo_bytes_next = '0;
            tst_next = '0;
            running_next = 1'b0;
            cursor_next = '0;
            if (!pass) begin
              tempo_count_next = '0;
              run_time_next = '0;
              mpqn_next = DEFAULT_MPQN;
              overflow_next = 1'b0;
            end
          end

          unique case (phase_next)
            PH_DELTA: begin
              vlq_next = {vlq_next[24:0], b[6:0]};
              if (!b[7]) begin
                tsum = SW'(tick_count_next) + SW'(vlq_next);
                ssum = SW'(tst_next) + SW'(vlq_next);
                tick_count_next = (tsum > TICK_MAX) ? TICK_WIDTH'(TICK_MAX) :
                                  tsum[TICK_WIDTH-1:0];
                tst_next = (ssum > TICK_MAX) ? TICK_WIDTH'(TICK_MAX) : ssum[TICK_WIDTH-1:0];
                vlq_next = '0;
                phase_next = PH_STATUS;
              end
            end
            PH_STATUS: begin
              cur_meta_next = '0;
              running_next = 1'b0;
              if (!b[7]) begin
                hi = last_status_next[7:4];
                running_next = 1'b1;
                if (hi == 4'h0 || hi == 4'hF) begin
                  cur_status_next = b;
                  res_code_next = RC_BAD_RUN;
                  res_stored_next = 1'b0;
                  res_time_next = '0;
                  st_next = ST_EMIT;
                  phase_next = PH_DONE;
                  early = 1'b1;
                end else begin
                  cur_status_next = last_status_next;
                  cur_size_next = (hi == 4'hC || hi == 4'hD) ? 32'd1 : 32'd2;
                  skip_next = cur_size_next - 32'd1;
                  if (skip_next == '0) begin
                    cmpl = 1'b1;
                  end else begin
                    phase_next = PH_DATA;
                  end
                end
              end else if (b[7:4] != 4'hF) begin
                cur_status_next = b;
                last_status_next = b;
                cur_size_next = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 32'd1 : 32'd2;
                skip_next = cur_size_next;
                phase_next = PH_DATA;
              end else if (b == STATUS_META) begin
                cur_status_next = b;
                phase_next = PH_META;
              end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
                cur_status_next = b;
                cur_size_next = '0;
                vlq_next = '0;
                phase_next = PH_LEN;
              end else begin
                cur_status_next = b;
                res_code_next = RC_BAD_EVENT;
                res_stored_next = 1'b0;
                res_time_next = '0;
                st_next = ST_EMIT;
                phase_next = PH_DONE;
                early = 1'b1;
              end
            end
            PH_META: begin
              cur_meta_next = b;
              if (b == META_END) begin
                // end of track: length byte is taken as present
                cur_size_next = 32'd2;
                phase_next = PH_DONE;
                early = 1'b1;
                res_code_next = RC_END;
                res_stored_next = 1'b1;
                res_time_next = '0;
                job_tempo_next = 1'b0;
                st_next = pass ? ST_LK_CHK : ST_EMIT;
              end else begin
                cur_size_next = '0;
                vlq_next = '0;
                phase_next = PH_LEN;
              end
            end
            PH_LEN: begin
              vlq_next = {vlq_next[24:0], b[6:0]};
              size1 = (cur_size_next == U32_MAX) ? U32_MAX : cur_size_next + 32'd1;
              cur_size_next = size1;
              if (!b[7]) begin
                lsum = 34'(vlq_next) + 34'(size1) + 34'(cur_status_next == STATUS_META);
                cur_size_next = (lsum > 34'(U32_MAX)) ? U32_MAX : lsum[31:0];
                skip_next = vlq_next;
                tempo_bytes_next = '0;
                if (skip_next == '0) begin
                  cmpl = 1'b1;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              if (cur_status_next == STATUS_META && cur_meta_next == META_TEMPO) begin
                idx = vlq_next - skip_next;
                if (idx == 32'd0) begin
                  tempo_bytes_next[23:16] = tempo_bytes_next[23:16] | b;
                end else if (idx == 32'd1) begin
                  tempo_bytes_next[15:8] = tempo_bytes_next[15:8] | b;
                end else if (idx == 32'd2) begin
                  tempo_bytes_next[7:0] = tempo_bytes_next[7:0] | b;
                end
              end
              if (skip_next != '0) begin
                skip_next = skip_next - 32'd1;
              end
              if (skip_next == '0) begin
                cmpl = 1'b1;
              end
            end
            PH_DONE: early = 1'b1;
            default: early = 1'b1;
          endcase

          if (cmpl) begin
            phase_next = PH_DELTA;
            if (!pass) begin
              job_tempo_next = (cur_status_next == STATUS_META) &&
                               (cur_meta_next == META_TEMPO);
              job_last_next = last;
              res_code_next = RC_END;
              res_stored_next = 1'b1;
              res_time_next = '0;
              n_res = last;
              if (job_tempo_next) begin
                st_next = ST_TSTART;
              end else if (last) begin
                st_next = ST_EMIT;
              end
            end else begin
              job_tempo_next = 1'b0;
              res_code_next = RC_EVENT;
              res_stored_next = 1'b1;
              res_time_next = '0;
              n_res = 1'b1;
              st_next = ST_LK_CHK;
            end
            if (last) begin
              phase_next = PH_DONE;
            end
          end

          if (!early && last && !n_res && phase_next != PH_DONE) begin
            res_code_next = RC_TRUNC;
            res_stored_next = 1'b0;
            res_time_next = '0;
            phase_next = PH_DONE;
            st_next = ST_EMIT;
          end
        end
      end
      ST_TSTART: begin
        seg_start = 1'b1;
        seg_ticks = tst;
        seg_mpqn = mpqn;
        st_next = ST_SEG;
      end
      ST_LK_CHK: begin
        cur = (CW'(cursor) >= tempo_count) ? '0 : cursor;
        cursor_next = cur;
        if ((CW + 1)'(cur) + (CW + 1)'(1) < (CW + 1)'(tempo_count)) begin
          ram_raddr = cur + AW'(1);
          st_next = ST_LK_NXT;
        end else if (tempo_count == '0) begin
          seg_start = 1'b1;
          base_us_next = '0;
          st_next = ST_SEG;
        end else begin
          ram_raddr = cur;
          st_next = ST_LK_CUR;
        end
      end
      ST_LK_NXT: begin
        if (rd_tick <= tick_count) begin
          cursor_next = cursor + AW'(1);
          st_next = ST_LK_CHK;
        end else begin
          ram_raddr = cursor;
          st_next = ST_LK_CUR;
        end
      end
      ST_LK_CUR: begin
        seg_start = 1'b1;
        if (rd_tick > tick_count) begin
          base_us_next = '0;
        end else begin
          seg_ticks = tick_count - rd_tick;
          seg_mpqn = rd_mpqn;
          base_us_next = rd_time;
        end
        st_next = ST_SEG;
      end
      ST_SEG: begin
        if (seg_done) begin
          st_next = job_tempo ? ST_TWR : ST_TSUM;
        end
      end
      ST_TWR: begin
        tsat = {1'b0, run_time} + {1'b0, seg_res};
        run_time_next = tsat[TIME_W] ? TIME_MAX : tsat[TIME_W-1:0];
        mpqn_next = tempo_bytes;
        tst_next = '0;
        if (tempo_count < CW'(TEMPO_ENTRIES)) begin
          ram_we = 1'b1;
          ram_wdata = {tick_count, tempo_bytes, run_time_next};
          tempo_count_next = tempo_count + CW'(1);
        end else begin
          overflow_next = 1'b1;
        end
        st_next = job_last ? ST_EMIT : ST_IDLE;
      end
      ST_TSUM: begin
        tsat = {1'b0, base_us} + {1'b0, seg_res};
        lk_us_next = tsat[TIME_W] ? TIME_MAX : tsat[TIME_W-1:0];
        st_next = ST_TOFS;
      end
      ST_TOFS: begin
        total = $signed({2'b00, lk_us}) + 42'(off_us);
        if (total[41]) begin
          res_code_next = RC_NEG_TIME;
          res_time_next = '0;
          phase_next = PH_DONE;
        end else begin
          res_time_next = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
        end
        st_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_load = 1'b1;
        st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_division <= DEFAULT_DIVISION;
      offset_ms <= '0;
      st <= ST_IDLE;
      m_tvalid <= 1'b0;
      phase <= PH_DELTA;
      tick_count <= '0;
      last_status <= '0;
      vlq <= '0;
      skip <= '0;
      cur_status <= '0;
      cur_meta <= '0;
      cur_size <= '0;
      tempo_bytes <= '0;
      tst <= '0;
      running <= 1'b0;
      run_time <= '0;
      mpqn <= DEFAULT_MPQN;
      tempo_count <= '0;
      cursor <= '0;
      overflow <= 1'b0;
      job_tempo <= 1'b0;
      job_last <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIME_DIV: time_division <= cfg_data[DIV_W-1:0];
          CFG_OFFSET:   offset_ms <= $signed(cfg_data);
          default:      ;
        endcase
      end
      st <= st_next;
      phase <= phase_next;
      tick_count <= tick_count_next;
      last_status <= last_status_next;
      vlq <= vlq_next;
      skip <= skip_next;
      cur_status <= cur_status_next;
      cur_meta <= cur_meta_next;
      cur_size <= cur_size_next;
      tempo_bytes <= tempo_bytes_next;
      tst <= tst_next;
      running <= running_next;
      run_time <= run_time_next;
      mpqn <= mpqn_next;
      tempo_count <= tempo_count_next;
      cursor <= cursor_next;
      overflow <= overflow_next;
      job_tempo <= job_tempo_next;
      job_last <= job_last_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_us <= 31'(offset_ms) * 31'sd1000;
    res_code <= res_code_next;
    res_stored <= res_stored_next;
    res_time <= res_time_next;
    base_us <= base_us_next;
    lk_us <= lk_us_next;
    if (out_load) begin
      m_tdata <= {6'b0, overflow, res_time, running,
                  (res_stored ? stored_bytes : 32'd0), cur_meta, cur_status, tick32};
      m_tuser <= res_code;
    end
  end

  mtep_ram #(
    .WIDTH (EW),
    .DEPTH (TEMPO_ENTRIES)
  ) u_tempo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtep_seg #(
    .TW (TICK_WIDTH)
  ) u_seg (
    .clk    (clk),
    .rst    (rst),
    .start  (seg_start),
    .ticks  (seg_ticks),
    .mpqn   (seg_mpqn),
    .div    (seg_div),
    .done   (seg_done),
    .result (seg_res)
  );

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> st == ST_IDLE)
    else $error("result pending while sequencer busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    tempo_count <= CW'(TEMPO_ENTRIES))
    else $error("tempo count beyond table depth");

  a_seg_done: assert property (@(posedge clk) disable iff (rst)
    seg_done |-> st == ST_SEG)
    else $error("segment unit finished outside wait state");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !m_tvalid)
    else $error("result appeared in the cycle after a request");
endmodule
